// ===== rtl/rrec_pkg.sv =====
// shared widths, codes and handshake types for the ray ring edge crossing block
package rrec_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int MAX_RING    = 64;
    localparam int COORD_WIDTH = 32;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W   = $clog2(MAX_RING + 1);
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int MUL_W   = DIFF_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int LEN_W   = DIFF_W;
    localparam int DEN_W   = 2 * DIFF_W;
    localparam int NUM_W   = DEN_W + LEN_W;
    localparam int REM_W   = DEN_W + 2;
    localparam int DIST_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VERTEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd1;

    localparam logic OP_SQRT = 1'b0;
    localparam logic OP_DIV  = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } t_rd_req;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [LEN_W-1:0] res;
    } t_rd_rsp;

endpackage

// ===== rtl/rrec_root_div.sv =====
// iterative square root and saturating divider sharing one wide subtractor
module rrec_root_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrec_pkg::t_rd_req              i_req,
    input  logic [rrec_pkg::NUM_W-1:0]     i_num,
    input  logic [rrec_pkg::DEN_W-1:0]     i_den,
    output rrec_pkg::t_rd_rsp              o_rsp
);
    import rrec_pkg::*;

    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = DIST_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS + 1);

    logic               r_busy;
    logic               r_op;
    logic [STEP_W-1:0]  r_cnt;
    logic [REM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_src;
    logic [LEN_W-1:0]   r_q;
    logic [DEN_W-1:0]   r_den;
    logic               r_done;
    logic               r_sat;

    logic [REM_W-1:0]   w_rem2;
    logic [REM_W-1:0]   w_trial;
    logic [REM_W:0]     w_diff;
    logic               w_ok;
    logic               w_sat;

    always_comb begin
        if (r_op == OP_SQRT) begin
            w_rem2  = {r_rem[REM_W-3:0], r_src[SQ_W-1 -: 2]};
            w_trial = {{(REM_W-LEN_W-2){1'b0}}, r_q, 2'b01};
        end else begin
            w_rem2  = {r_rem[REM_W-2:0], r_src[DIST_W-1]};
            w_trial = {2'b00, r_den};
        end
        w_diff = {1'b0, w_rem2} - {1'b0, w_trial};
        w_ok   = !w_diff[REM_W];
        w_sat  = i_num[NUM_W-1:DIST_W] >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op  <= i_req.op;
                r_q   <= '0;
                r_sat <= 1'b0;
                r_src <= i_num;
                r_den <= i_den;
                if (i_req.op == OP_SQRT) begin
                    r_rem  <= '0;
                    r_cnt  <= STEP_W'(SQRT_STEPS);
                    r_busy <= 1'b1;
                end else if (w_sat) begin
                    // quotient would not fit 32 bits
                    r_sat  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= REM_W'(i_num[NUM_W-1:DIST_W]);
                    r_cnt  <= STEP_W'(DIV_STEPS);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ok ? w_diff[REM_W-1:0] : w_rem2;
                r_q   <= {r_q[LEN_W-2:0], w_ok};
                r_src <= (r_op == OP_SQRT) ? (r_src << 2) : (r_src << 1);
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.res  = r_q;

endmodule

// ===== rtl/ray_ring_edge_crossing.sv =====
// top level: vertex store, edge walk sequencer, shared multiplier, result register
//
//  channel | handshake                    | payload
//  --------+------------------------------+-----------------------------------------
//  input   | i_valid / o_stall            | i_action, i_vertex_index, i_pos_*, i_start_*,
//          |                              | i_end_*, i_max_distance, i_best_distance
//  result  | o_valid / i_stall            | o_status, o_distance, o_edge_a_*, o_edge_b_*
//  config  | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// a vertex write is stored as it is accepted; a query walks the ring edge by edge
// (one store read and two passes through the shared multiplier per edge),
// then runs the cross products, 33 square root steps and 32 divide steps;
// the vertex count of a ring is capped at 64
// reset is synchronous and clears control state only; the store is not cleared
// a finished result waits in the output register; the next item is accepted meanwhile
module ray_ring_edge_crossing (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_action,
    input  logic [rrec_pkg::ADDR_W-1:0]           i_vertex_index,
    input  logic signed [rrec_pkg::COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [rrec_pkg::COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [rrec_pkg::COORD_WIDTH-1:0] i_start_x,
    input  logic signed [rrec_pkg::COORD_WIDTH-1:0] i_start_y,
    input  logic signed [rrec_pkg::COORD_WIDTH-1:0] i_end_x,
    input  logic signed [rrec_pkg::COORD_WIDTH-1:0] i_end_y,
    input  logic [rrec_pkg::DIST_W-1:0]           i_max_distance,
    input  logic [rrec_pkg::DIST_W-1:0]           i_best_distance,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_status,
    output logic [rrec_pkg::DIST_W-1:0]           o_distance,
    output logic signed [rrec_pkg::COORD_WIDTH-1:0] o_edge_a_x,
    output logic signed [rrec_pkg::COORD_WIDTH-1:0] o_edge_a_y,
    output logic signed [rrec_pkg::COORD_WIDTH-1:0] o_edge_b_x,
    output logic signed [rrec_pkg::COORD_WIDTH-1:0] o_edge_b_y,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rrec_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rrec_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import rrec_pkg::*;

    localparam int CW = COORD_WIDTH;

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_M1   = 5'd2;
    localparam logic [4:0] S_M2   = 5'd3;
    localparam logic [4:0] S_SIDE = 5'd4;
    localparam logic [4:0] S_E    = 5'd5;
    localparam logic [4:0] S_C1   = 5'd6;
    localparam logic [4:0] S_C2   = 5'd7;
    localparam logic [4:0] S_C3   = 5'd8;
    localparam logic [4:0] S_C4   = 5'd9;
    localparam logic [4:0] S_C5   = 5'd10;
    localparam logic [4:0] S_C6   = 5'd11;
    localparam logic [4:0] S_C7   = 5'd12;
    localparam logic [4:0] S_SQ   = 5'd13;
    localparam logic [4:0] S_N1   = 5'd14;
    localparam logic [4:0] S_N2   = 5'd15;
    localparam logic [4:0] S_N3   = 5'd16;
    localparam logic [4:0] S_DV   = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    // vertex store, x in the low half
    logic [2*CW-1:0] r_mem [STORE_DEPTH];
    logic [2*CW-1:0] r_rd;

    // configuration
    logic [ADDR_W-1:0] r_first_vertex;
    logic [CNT_W-1:0]  r_vertex_count;

    // sequencer and query context
    logic [4:0]               r_state;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_i;
    logic [CNT_W-1:0]         r_vidx;
    logic                     r_first;
    logic                     r_aleft;
    logic signed [CW-1:0]     r_sx, r_sy;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [DIFF_W-1:0] r_ex, r_ey;
    logic signed [CW-1:0]     r_ax, r_ay, r_bx, r_by;
    logic [DIST_W-1:0]        r_maxd, r_best;
    logic signed [PROD_W-1:0] r_prod, r_p1, r_coe;
    logic [DEN_W-1:0]         r_den;
    logic [LEN_W-1:0]         r_len;
    logic [1:0]               r_res_status;
    logic [DIST_W-1:0]        r_res_dist;
    logic                     r_res_edges;

    // output register
    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic [DIST_W-1:0]        r_out_dist;
    logic signed [CW-1:0]     r_out_ax, r_out_ay, r_out_bx, r_out_by;

    // shared multiplier operands
    logic signed [MUL_W-1:0]  w_ma, w_mb;

    logic                     w_acc;
    logic                     w_out_free;
    logic signed [DIFF_W-1:0] w_in_dx, w_in_dy;
    logic [CNT_W-1:0]         w_n_sat;
    logic signed [PROD_W-1:0] w_cross;
    logic [PROD_W-1:0]        w_sum;
    logic                     w_left, w_right;
    logic [ADDR_W-1:0]        w_addr;
    logic [CNT_W:0]           w_i2;
    logic [NUM_W-1:0]         w_num;
    logic [DIFF_W-1:0]        w_adx, w_ady;
    logic [DIST_W-1:0]        w_t;
    t_rd_req                  w_req;
    t_rd_rsp                  w_rsp;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;

    always_comb begin
        w_in_dx = DIFF_W'(i_end_x) - DIFF_W'(i_start_x);
        w_in_dy = DIFF_W'(i_end_y) - DIFF_W'(i_start_y);
        w_n_sat = (r_vertex_count > CNT_W'(MAX_RING)) ? CNT_W'(MAX_RING) : r_vertex_count;
        w_cross = r_p1 - r_prod;
        w_sum   = r_p1 + r_prod;
        w_right = !w_cross[PROD_W-1] && (w_cross != '0);
        w_left  = !w_right;
        w_addr  = r_first_vertex + ADDR_W'(r_vidx);
        w_i2    = {1'b0, r_i} + (CNT_W+1)'(2);
        w_num   = {r_prod[DEN_W-1:0], {LEN_W{1'b0}}} + NUM_W'(r_p1[DEN_W-1:0]);
        w_adx   = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
        w_ady   = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
        w_t     = w_rsp.res[DIST_W-1:0];
    end

    // operand selection for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_M1: begin
                w_ma = MUL_W'(DIFF_W'($signed(r_rd[CW-1:0])) - DIFF_W'(r_sx));
                w_mb = MUL_W'(r_dy);
            end
            S_M2: begin
                w_ma = MUL_W'(DIFF_W'(r_by) - DIFF_W'(r_sy));
                w_mb = MUL_W'(r_dx);
            end
            S_C1: begin
                w_ma = MUL_W'(DIFF_W'(r_sx) - DIFF_W'(r_ax));
                w_mb = MUL_W'(r_ey);
            end
            S_C2: begin
                w_ma = MUL_W'(DIFF_W'(r_sy) - DIFF_W'(r_ay));
                w_mb = MUL_W'(r_ex);
            end
            S_C3: begin
                w_ma = MUL_W'(r_dx);
                w_mb = MUL_W'(r_ey);
            end
            S_C4: begin
                w_ma = MUL_W'(r_dy);
                w_mb = MUL_W'(r_ex);
            end
            S_C5: begin
                w_ma = $signed({1'b0, w_adx});
                w_mb = $signed({1'b0, w_adx});
            end
            S_C6: begin
                w_ma = $signed({1'b0, w_ady});
                w_mb = $signed({1'b0, w_ady});
            end
            S_N1: begin
                w_ma = $signed({1'b0, r_coe[LEN_W-1:0]});
                w_mb = $signed({1'b0, r_len});
            end
            S_N2: begin
                w_ma = $signed({1'b0, r_coe[DEN_W-1:LEN_W]});
                w_mb = $signed({1'b0, r_len});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        w_req.start = (r_state == S_C7) || (r_state == S_N3);
        w_req.op    = (r_state == S_N3) ? OP_DIV : OP_SQRT;
    end

    rrec_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_num   ((r_state == S_N3) ? w_num : NUM_W'(w_sum[SQ_W-1:0])),
        .i_den   (r_den),
        .o_rsp   (w_rsp)
    );

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_acc && i_action == ACT_WRITE) begin
            r_mem[i_vertex_index] <= {i_pos_y, i_pos_x};
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[w_addr];
        end
    end

    // product pipeline: r_p1 keeps the previous product
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_p1   <= r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_vertex <= '0;
            r_vertex_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_FIRST_VERTEX) begin
                r_first_vertex <= i_cfg_data[ADDR_W-1:0];
            end else if (i_cfg_index == CFG_VERTEX_COUNT) begin
                r_vertex_count <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_action == ACT_QUERY) begin
                        r_sx        <= i_start_x;
                        r_sy        <= i_start_y;
                        r_dx        <= w_in_dx;
                        r_dy        <= w_in_dy;
                        r_maxd      <= i_max_distance;
                        r_best      <= i_best_distance;
                        r_n         <= w_n_sat;
                        r_i         <= '0;
                        r_vidx      <= '0;
                        r_first     <= 1'b1;
                        r_res_edges <= 1'b0;
                        r_res_status <= ST_NONE;
                        r_res_dist  <= i_best_distance;
                        if (w_n_sat == '0) begin
                            // empty ring
                            r_state <= S_OUT;
                        end else if (w_in_dx == '0 && w_in_dy == '0) begin
                            r_res_status <= ST_ZERO;
                            r_res_dist   <= '0;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_M1;
                S_M1: begin
                    r_bx    <= $signed(r_rd[CW-1:0]);
                    r_by    <= $signed(r_rd[2*CW-1:CW]);
                    r_state <= S_M2;
                end
                S_M2: r_state <= S_SIDE;
                S_SIDE: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_ax    <= r_bx;
                        r_ay    <= r_by;
                        r_aleft <= w_left;
                        r_vidx  <= (r_n == CNT_W'(1)) ? '0 : CNT_W'(1);
                        r_state <= S_RD;
                    end else if (r_aleft && w_right) begin
                        r_state <= S_E;
                    end else if (r_i + 1'b1 == r_n) begin
                        // no crossing edge on the ring
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_ax    <= r_bx;
                        r_ay    <= r_by;
                        r_aleft <= w_left;
                        r_vidx  <= (w_i2 == {1'b0, r_n}) ? '0 : w_i2[CNT_W-1:0];
                        r_state <= S_RD;
                    end
                end
                S_E: begin
                    r_ex    <= DIFF_W'(r_bx) - DIFF_W'(r_ax);
                    r_ey    <= DIFF_W'(r_by) - DIFF_W'(r_ay);
                    r_state <= S_C1;
                end
                S_C1: r_state <= S_C2;
                S_C2: r_state <= S_C3;
                S_C3: begin
                    r_coe   <= w_cross;
                    r_state <= S_C4;
                end
                S_C4: r_state <= S_C5;
                S_C5: begin
                    // need start on the far side and ray pointing into the edge
                    r_den <= DEN_W'(-w_cross);
                    if (r_coe[PROD_W-1] || r_coe == '0 || !w_cross[PROD_W-1]) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_C6;
                    end
                end
                S_C6: r_state <= S_C7;
                S_C7: r_state <= S_SQ;
                S_SQ: begin
                    if (w_rsp.done) begin
                        r_len   <= w_rsp.res;
                        r_state <= S_N1;
                    end
                end
                S_N1: r_state <= S_N2;
                S_N2: r_state <= S_N3;
                S_N3: r_state <= S_DV;
                S_DV: begin
                    if (w_rsp.done) begin
                        if (!w_rsp.sat && w_t != '0 && w_t < r_maxd && w_t < r_best) begin
                            r_res_status <= ST_HIT;
                            r_res_dist   <= w_t;
                            r_res_edges  <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_dist   <= r_res_dist;
            r_out_ax     <= r_res_edges ? r_ax : '0;
            r_out_ay     <= r_res_edges ? r_ay : '0;
            r_out_bx     <= r_res_edges ? r_bx : '0;
            r_out_by     <= r_res_edges ? r_by : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_distance = r_out_dist;
    assign o_edge_a_x = r_out_ax;
    assign o_edge_a_y = r_out_ay;
    assign o_edge_b_x = r_out_bx;
    assign o_edge_b_y = r_out_by;

endmodule
